// ===== hdl/ghash_pkg.sv =====
// Shared types, constants and GF(2^128) helper functions for the GHASH core.
`default_nettype none

package ghash_pkg;

    localparam int BLOCK_W    = 128;
    localparam int HALF_W     = 64;
    localparam int DIGIT_W    = 32;                 // multiplier bits consumed per cycle
    localparam int STEPS      = BLOCK_W / DIGIT_W;  // digit steps per multiply
    localparam int STEP_CNT_W = $clog2(STEPS);
    localparam int TOTAL_W    = 32;
    localparam int BYTES_W    = 5;
    localparam int MAX_BYTES  = 16;
    localparam int QDEPTH     = 2;
    localparam int QADDR_W    = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [7:0] GF_REDUCE_TOP = 8'hE1;

    typedef enum logic [1:0] {
        KIND_AAD    = 2'd0,
        KIND_TEXT   = 2'd1,
        KIND_FINISH = 2'd2
    } t_kind;

    typedef enum logic {
        CFG_SUBKEY_HIGH = 1'b0,
        CFG_SUBKEY_LOW  = 1'b1
    } t_cfg_index;

    // one unit of work for the multiplier
    typedef struct packed {
        logic               fin;  // length block: emit and clear afterwards
        logic [BLOCK_W-1:0] blk;
    } t_qentry;

    // Reduce overflow coefficients x^128..x^(128+DIGIT_W-1), held in bit-reflected
    // order (bit DIGIT_W-1 is x^128), back into the field.
    function automatic logic [BLOCK_W-1:0] gf_fold(input logic [DIGIT_W-1:0] t);
        logic [BLOCK_W-1:0] r;
        logic [BLOCK_W-1:0] top;
        r   = '0;
        top = {GF_REDUCE_TOP, {(BLOCK_W-8){1'b0}}};
        for (int p = 0; p < DIGIT_W; p++) begin
            if (t[p]) begin
                r ^= top >> (DIGIT_W - 1 - p);
            end
        end
        return r;
    endfunction

    // v * (d as a digit of DIGIT_W coefficients, MSB = lowest degree), reduced
    function automatic logic [BLOCK_W-1:0] gf_digit_mul(input logic [BLOCK_W-1:0] v,
                                                       input logic [DIGIT_W-1:0] d);
        logic [BLOCK_W+DIGIT_W-1:0] s;
        logic [BLOCK_W+DIGIT_W-1:0] ext;
        s   = '0;
        ext = {v, {DIGIT_W{1'b0}}};
        for (int j = 0; j < DIGIT_W; j++) begin
            if (d[DIGIT_W-1-j]) begin
                s ^= ext >> j;
            end
        end
        return s[BLOCK_W+DIGIT_W-1:DIGIT_W] ^ gf_fold(s[DIGIT_W-1:0]);
    endfunction

    // v * x^DIGIT_W
    function automatic logic [BLOCK_W-1:0] gf_mul_xd(input logic [BLOCK_W-1:0] v);
        return (v >> DIGIT_W) ^ gf_fold(v[DIGIT_W-1:0]);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ghash_front.sv =====
// Front end: classifies requests, masks partial chunks, keeps byte totals.
`default_nettype none

module ghash_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_accept,
    input  wire logic [1:0]                     i_kind,
    input  wire logic [ghash_pkg::HALF_W-1:0]   i_chunk_high,
    input  wire logic [ghash_pkg::HALF_W-1:0]   i_chunk_low,
    input  wire logic [ghash_pkg::BYTES_W-1:0]  i_valid_bytes,
    output      logic                           o_wr,
    output      ghash_pkg::t_qentry             o_entry
);

    logic [ghash_pkg::TOTAL_W-1:0] r_aad_total, n_aad_total;
    logic [ghash_pkg::TOTAL_W-1:0] r_text_total, n_text_total;

    logic [ghash_pkg::BYTES_W-1:0] nbytes;
    logic [7:0]                    mask_shift;
    logic [ghash_pkg::BLOCK_W-1:0] mask;
    logic [ghash_pkg::TOTAL_W:0]   aad_sum, text_sum;
    logic [ghash_pkg::TOTAL_W-1:0] aad_sat, text_sat;

    assign nbytes     = (i_valid_bytes > ghash_pkg::BYTES_W'(ghash_pkg::MAX_BYTES))
                      ? ghash_pkg::BYTES_W'(ghash_pkg::MAX_BYTES) : i_valid_bytes;
    assign mask_shift = {nbytes, 3'b000};
    assign mask       = ~({ghash_pkg::BLOCK_W{1'b1}} >> mask_shift);

    // saturating byte totals
    assign aad_sum  = {1'b0, r_aad_total}  + (ghash_pkg::TOTAL_W+1)'(nbytes);
    assign text_sum = {1'b0, r_text_total} + (ghash_pkg::TOTAL_W+1)'(nbytes);
    assign aad_sat  = aad_sum[ghash_pkg::TOTAL_W]  ? '1 : aad_sum[ghash_pkg::TOTAL_W-1:0];
    assign text_sat = text_sum[ghash_pkg::TOTAL_W] ? '1 : text_sum[ghash_pkg::TOTAL_W-1:0];

    always_comb begin
        o_wr          = 1'b0;
        o_entry.fin   = 1'b0;
        o_entry.blk   = {i_chunk_high, i_chunk_low} & mask;
        n_aad_total   = r_aad_total;
        n_text_total  = r_text_total;
        if (i_accept) begin
            case (ghash_pkg::t_kind'(i_kind))
                ghash_pkg::KIND_AAD: begin
                    o_wr        = (nbytes != '0);
                    n_aad_total = aad_sat;
                end
                ghash_pkg::KIND_TEXT: begin
                    o_wr         = (nbytes != '0);
                    n_text_total = text_sat;
                end
                ghash_pkg::KIND_FINISH: begin
                    // length block: bit counts, big-endian halves
                    o_wr         = 1'b1;
                    o_entry.fin  = 1'b1;
                    o_entry.blk  = {{(ghash_pkg::HALF_W-ghash_pkg::TOTAL_W-3){1'b0}},
                                    r_aad_total, 3'b000,
                                    {(ghash_pkg::HALF_W-ghash_pkg::TOTAL_W-3){1'b0}},
                                    r_text_total, 3'b000};
                    n_aad_total  = '0;
                    n_text_total = '0;
                end
                default: begin
                    o_wr = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aad_total  <= '0;
            r_text_total <= '0;
        end else begin
            r_aad_total  <= n_aad_total;
            r_text_total <= n_text_total;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ghash_queue.sv =====
// Two-entry queue between the front end and the multiplier.
`default_nettype none

module ghash_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_wr,
    input  wire ghash_pkg::t_qentry  i_wdata,
    output      logic                o_full,
    input  wire logic                i_rd,
    output      ghash_pkg::t_qentry  o_rdata,
    output      logic                o_empty
);

    ghash_pkg::t_qentry                r_mem [ghash_pkg::QDEPTH];
    logic [ghash_pkg::QADDR_W-1:0]     r_wptr, r_rptr;
    logic [ghash_pkg::QCNT_W-1:0]      r_count;
    logic                              do_wr, do_rd;

    assign o_full  = (r_count == ghash_pkg::QCNT_W'(ghash_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ghash_pkg::QCNT_W'(ghash_pkg::QDEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ===== hdl/ghash_back.sv =====
// Back end: digit-serial GF(2^128) multiplier, running hash and result register.
`default_nettype none

module ghash_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr,
    input  wire logic                          i_cfg_index,
    input  wire logic [ghash_pkg::HALF_W-1:0]  i_cfg_data,
    input  wire logic                          i_q_empty,
    input  wire ghash_pkg::t_qentry            i_q_entry,
    output      logic                          o_q_pop,
    output      logic                          o_out_valid,
    output      logic [ghash_pkg::BLOCK_W-1:0] o_out,
    input  wire logic                          i_out_pop
);

    logic [ghash_pkg::BLOCK_W-1:0]    r_subkey;
    logic [ghash_pkg::BLOCK_W-1:0]    r_hash;
    logic [ghash_pkg::BLOCK_W-1:0]    r_x, r_v, r_z;
    logic [ghash_pkg::STEP_CNT_W-1:0] r_cnt;
    logic                             r_busy, r_fin;
    logic                             r_out_valid;
    logic [ghash_pkg::BLOCK_W-1:0]    r_out;

    logic                             start, last;
    logic [ghash_pkg::BLOCK_W-1:0]    x_cur, v_cur, z_cur;
    logic [ghash_pkg::BLOCK_W-1:0]    x_nxt, v_nxt, z_nxt;

    // a finish item waits until the result register is free
    assign start = !r_busy && !i_q_empty && (!i_q_entry.fin || !r_out_valid);
    assign last  = r_busy && (r_cnt == ghash_pkg::STEP_CNT_W'(ghash_pkg::STEPS - 1));
    assign o_q_pop = start;

    always_comb begin
        if (start) begin
            x_cur = r_hash ^ i_q_entry.blk;
            v_cur = r_subkey;
            z_cur = '0;
        end else begin
            x_cur = r_x;
            v_cur = r_v;
            z_cur = r_z;
        end
        z_nxt = z_cur ^ ghash_pkg::gf_digit_mul(v_cur,
                    x_cur[ghash_pkg::BLOCK_W-1 -: ghash_pkg::DIGIT_W]);
        v_nxt = ghash_pkg::gf_mul_xd(v_cur);
        x_nxt = x_cur << ghash_pkg::DIGIT_W;
    end

    always_ff @(posedge i_clk) begin
        if (start || r_busy) begin
            r_x <= x_nxt;
            r_v <= v_nxt;
            r_z <= z_nxt;
        end
        if (start) begin
            r_fin <= i_q_entry.fin;
        end
        if (last && r_fin) begin
            r_out <= z_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_subkey    <= '0;
            r_hash      <= '0;
            r_cnt       <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                case (ghash_pkg::t_cfg_index'(i_cfg_index))
                    ghash_pkg::CFG_SUBKEY_HIGH: begin
                        r_subkey[ghash_pkg::BLOCK_W-1:ghash_pkg::HALF_W] <= i_cfg_data;
                    end
                    ghash_pkg::CFG_SUBKEY_LOW: begin
                        r_subkey[ghash_pkg::HALF_W-1:0] <= i_cfg_data;
                    end
                    default: begin
                        r_subkey <= r_subkey;
                    end
                endcase
            end
            if (i_out_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            if (start) begin
                r_busy <= 1'b1;
                r_cnt  <= ghash_pkg::STEP_CNT_W'(1);
            end else if (last) begin
                r_busy <= 1'b0;
                r_cnt  <= '0;
                if (r_fin) begin
                    r_hash      <= '0;
                    r_out_valid <= 1'b1;
                end else begin
                    r_hash <= z_nxt;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("multiplier busy with zero step count");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(last && r_fin))
        else $error("result raised without a finished length block");

    a_hash_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (last && r_fin) |=> (r_hash == '0))
        else $error("running hash not cleared after finish");

endmodule

`default_nettype wire

// ===== hdl/ghash_authenticator_core.sv =====
// Top level of the GCM GHASH core: front end, work queue and multiplier.
// Usage:
//  - Input side is a queue: drive i_kind, chunk halves and i_valid_bytes with push;
//    a request is taken on a clock edge with push high and full low.
//  - AAD and ciphertext requests are masked to their valid bytes and queued for the
//    multiplier; requests with zero valid bytes or kind 3 only occupy the accept cycle.
//  - A finish request queues the length block and clears the byte totals at once.
//  - Result side is a queue: while empty is low, o_hash_high/o_hash_low hold the
//    hash; pop high with empty low takes it.
//  - Flow: one request per cycle while full is low, into a 2-deep queue; the
//    multiplier works through each queued 128-bit block one 32-bit digit a cycle and
//    takes a new block only after the last digit of the one before.
//  - A finish request accepted with the multiplier idle is written into the queue,
//    started from the queue head, and its result is registered at the last digit step.
//  - A result that is not popped holds; the next finish waits at the head of the
//    queue, requests behind it stall, and full rises once the queue fills.
//  - Configuration: i_cfg_valid/o_cfg_ready, index 0 subkey high, 1 subkey low.
//    Ready is always high; write only while the core is idle.
//  - Reset (i_rst_n low, synchronous): subkey, running hash, totals, queue and the
//    result valid flag are cleared; the result data register is not reset.
`default_nettype none

module ghash_authenticator_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output      logic                          full,
    input  wire logic [1:0]                    i_kind,
    input  wire logic [ghash_pkg::HALF_W-1:0]  i_chunk_high,
    input  wire logic [ghash_pkg::HALF_W-1:0]  i_chunk_low,
    input  wire logic [ghash_pkg::BYTES_W-1:0] i_valid_bytes,
    output      logic                          empty,
    input  wire logic                          pop,
    output      logic [ghash_pkg::HALF_W-1:0]  o_hash_high,
    output      logic [ghash_pkg::HALF_W-1:0]  o_hash_low,
    input  wire logic                          i_cfg_valid,
    output      logic                          o_cfg_ready,
    input  wire logic                          i_cfg_index,
    input  wire logic [ghash_pkg::HALF_W-1:0]  i_cfg_data
);

    logic                          in_accept;
    logic                          q_wr;
    ghash_pkg::t_qentry            q_wdata;
    logic                          q_full;
    logic                          q_pop;
    ghash_pkg::t_qentry            q_rdata;
    logic                          q_empty;
    logic                          out_valid;
    logic [ghash_pkg::BLOCK_W-1:0] out_hash;

    assign full        = q_full;
    assign in_accept   = push && !q_full;
    assign o_cfg_ready = 1'b1;

    ghash_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_kind        (i_kind),
        .i_chunk_high  (i_chunk_high),
        .i_chunk_low   (i_chunk_low),
        .i_valid_bytes (i_valid_bytes),
        .o_wr          (q_wr),
        .o_entry       (q_wdata)
    );

    ghash_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_rd    (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    ghash_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_empty   (q_empty),
        .i_q_entry   (q_rdata),
        .o_q_pop     (q_pop),
        .o_out_valid (out_valid),
        .o_out       (out_hash),
        .i_out_pop   (pop)
    );

    assign empty       = !out_valid;
    assign o_hash_high = out_hash[ghash_pkg::BLOCK_W-1:ghash_pkg::HALF_W];
    assign o_hash_low  = out_hash[ghash_pkg::HALF_W-1:0];

endmodule

`default_nettype wire
